// ----- hw/rtl/vad_pkg.sv -----
// Package for the vertex attribute decoder: payload types, format codes and conversion functions.
`default_nettype none
package vad_pkg;

   localparam logic [3:0] FMT_HALF2  = 4'd1;
   localparam logic [3:0] FMT_FLOAT  = 4'd2;
   localparam logic [3:0] FMT_HALF4  = 4'd3;
   localparam logic [3:0] FMT_FLOAT2 = 4'd5;
   localparam logic [3:0] FMT_FLOAT3 = 4'd6;
   localparam logic [3:0] FMT_FLOAT4 = 4'd7;
   localparam logic [3:0] FMT_UBYTE4 = 4'd8;
   localparam logic [3:0] FMT_UNORM8 = 4'd9;
   localparam logic [3:0] FMT_SNORM8 = 4'd10;

   localparam logic [3:0] SEM_POSITION = 4'd0;
   localparam logic [3:0] SEM_WEIGHTS  = 4'd1;
   localparam logic [3:0] SEM_INDICES  = 4'd2;
   localparam logic [3:0] SEM_NORMAL   = 4'd3;
   localparam logic [3:0] SEM_COLOUR0  = 4'd4;
   localparam logic [3:0] SEM_COLOUR1  = 4'd5;
   localparam logic [3:0] SEM_TANGENT  = 4'd14;

   localparam logic [0:0] CSR_ENABLE_MASK = 1'd0;
   localparam logic [0:0] CSR_TYPE_CODES  = 1'd1;

   // What a lane does with its source element.
   typedef enum logic [2:0] {
      LANE_ZERO,
      LANE_PASS,
      LANE_HALF,
      LANE_UNORM,
      LANE_SNORM,
      LANE_UBYTE,
      LANE_INT
   } lane_op_type;

   typedef struct packed {
      logic [3:0]  semantic;
      logic [31:0] raw_word0;
      logic [31:0] raw_word1;
      logic [31:0] raw_word2;
      logic [31:0] raw_word3;
   } req_type;

   typedef struct packed {
      logic        valid_res;
      logic [3:0]  attribute;
      logic [2:0]  value_count;
      logic        is_integer;
      logic [31:0] value0;
      logic [31:0] value1;
      logic [31:0] value2;
      logic [31:0] value3;
   } rsp_type;

   // Per-lane control decided by the front end.
   typedef struct packed {
      lane_op_type op;
      logic        trunc;
      logic        half;
      logic [31:0] src;
   } lane_ctl_type;

   // Control that bypasses the lanes to the merging stage.
   typedef struct packed {
      logic       ok;
      logic [3:0] attribute;
      logic [2:0] value_count;
      logic       is_integer;
   } head_type;

   // Single-precision bits of b/255, correctly rounded from the double quotient.
   function automatic logic [31:0] unorm_bits(input logic [7:0] b);
      logic [31:0] r;
      logic [7:0]  e;
      logic [4:0]  lz;
      logic [63:0] q;
      logic [22:0] m;
      logic [7:0]  t;
      begin
         r = '0;
         if (b == 8'd255) begin
            r = 32'h3F800000;
         end else if (b != 8'd0) begin
            lz = 5'd0;
            t = b;
            for (int k = 0; k < 8; k++) begin
               if (t[7] == 1'b0) begin
                  t = {t[6:0], 1'b0};
                  lz = lz + 5'd1;
               end
            end
            // b/255 = 0.bbbbbbbb repeating; normalise the repeated pattern.
            q = {b, b, b, b, b, b, b, b} << lz;
            e = 8'd126 - {3'd0, lz};
            m = q[62:40];
            if (q[39] && (q[38:0] != '0 || m[0])) begin
               r = {1'b0, e, m} + 32'd1;
            end else begin
               r = {1'b0, e, m};
            end
         end
         return r;
      end
   endfunction

   // Single-precision bits of b/127 for b below 127; the quotient repeats b every seven bits.
   function automatic logic [31:0] snorm_bits(input logic [6:0] b);
      logic [31:0] r;
      logic [7:0]  e;
      logic [4:0]  lz;
      logic [63:0] q;
      logic [22:0] m;
      logic [6:0]  t;
      begin
         r = '0;
         if (b != 7'd0) begin
            lz = 5'd0;
            t = b;
            for (int k = 0; k < 7; k++) begin
               if (t[6] == 1'b0) begin
                  t = {t[5:0], 1'b0};
                  lz = lz + 5'd1;
               end
            end
            q = {b, b, b, b, b, b, b, b, b, b[6]} << lz;
            e = 8'd126 - {3'd0, lz};
            m = q[62:40];
            if (q[39]) begin
               r = {1'b0, e, m} + 32'd1;
            end else begin
               r = {1'b0, e, m};
            end
         end
         return r;
      end
   endfunction

   // Single-precision bits of a small integer 0..255.
   function automatic logic [31:0] int8_bits(input logic [7:0] b);
      logic [31:0] r;
      logic [7:0]  t;
      logic [3:0]  p;
      begin
         r = '0;
         t = b;
         p = 4'd0;
         for (int k = 0; k < 8; k++) begin
            if (b[k]) p = 4'(k);
         end
         if (b != 8'd0) begin
            t = b << (4'd7 - p);
            r = {1'b0, 8'd127 + {4'd0, p}, t[6:0], 16'd0};
         end
         return r;
      end
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/vad_lane.sv -----
// One conversion lane: turns one source element into single-precision bits or an integer.
`default_nettype none
module vad_lane (
   input  wire logic                  clock,
   input  wire vad_pkg::lane_ctl_type ctl,
   output logic [31:0]                value_ff
);

   logic [31:0] value_in;
   logic [15:0] h;
   logic [4:0]  he;
   logic [9:0]  hm;
   logic [3:0]  hp;
   logic [9:0]  hsh;
   logic [31:0] hv;
   logic [7:0]  sb;
   logic [31:0] f;
   logic [8:0]  fe;
   logic [55:0] fsh;
   logic [31:0] snorm_mag;

   always_comb begin
      value_in = '0;
      h = ctl.src[15:0];
      he = h[14:10];
      hm = h[9:0];
      hp = 4'd0;
      for (int k = 0; k < 10; k++) begin
         if (hm[k]) hp = 4'(k);
      end
      hsh = hm << (4'd10 - hp);
      if (he == 5'd0) begin
         if (hm == '0) hv = {h[15], 31'd0};
         else hv = {h[15], 8'd103 + {4'd0, hp}, hsh[9:0], 13'd0};
      end else if (he == 5'h1F) begin
         hv = {h[15], (hm == '0) ? 31'h7F800000 : 31'h7FC00000};
      end else begin
         hv = {h[15], {3'd0, he} + 8'd112, hm, 13'd0};
      end
      sb = ctl.src[7:0];
      // Half sources are widened to single before truncation to an integer.
      f = ctl.half ? hv : ctl.src;
      fe = {1'b0, f[30:23]};
      fsh = '0;
      snorm_mag = '0;
      case (ctl.op)
         vad_pkg::LANE_ZERO: value_in = '0;
         vad_pkg::LANE_PASS: value_in = ctl.src;
         vad_pkg::LANE_HALF: value_in = hv;
         vad_pkg::LANE_UNORM: value_in = vad_pkg::unorm_bits(sb);
         vad_pkg::LANE_UBYTE: value_in = vad_pkg::int8_bits(sb);
         vad_pkg::LANE_SNORM: begin
            // Bytes of -127 and -128 both give -1; the rest are scaled by 1/127.
            if (sb[7] && sb <= 8'h81) begin
               value_in = 32'hBF800000;
            end else if (sb[7]) begin
               snorm_mag = vad_pkg::snorm_bits(7'(9'd256 - {1'b0, sb}));
               value_in = {1'b1, snorm_mag[30:0]};
            end else if (sb == 8'd127) begin
               value_in = 32'h3F800000;
            end else begin
               value_in = vad_pkg::snorm_bits(sb[6:0]);
            end
         end
         vad_pkg::LANE_INT: begin
            if (ctl.trunc) begin
               if (f[31] || fe < 9'd127) value_in = '0;
               else if (fe == 9'd255 && f[22:0] != '0) value_in = '0;
               else if (fe >= 9'd159) value_in = 32'hFFFFFFFF;
               else begin
                  fsh = {32'd0, 1'b1, f[22:0]} << (fe - 9'd127);
                  value_in = fsh[54:23];
               end
            end else begin
               value_in = {24'd0, sb};
            end
         end
         default: value_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule
`default_nettype wire

// ----- hw/rtl/vad_front.sv -----
// Front end: slot lookup, format decode and lane control for one word.
`default_nettype none
module vad_front #(
   parameter int ATTR_SLOTS = 16
) (
   input  wire vad_pkg::req_type      req,
   input  wire logic [15:0]           enable_mask,
   input  wire logic [63:0]           type_codes,
   output vad_pkg::lane_ctl_type      ctl [4],
   output vad_pkg::head_type          head
);

   logic [3:0]  s;
   logic [3:0]  f;
   logic [31:0] w [4];
   logic [7:0]  by [16];
   logic [2:0]  n;
   logic        four;
   logic        known;
   vad_pkg::lane_op_type op;
   logic        half;

   always_comb begin
      s = req.semantic;
      f = type_codes[{s, 2'b00} +: 4];
      w[0] = req.raw_word0;
      w[1] = req.raw_word1;
      w[2] = req.raw_word2;
      w[3] = req.raw_word3;
      for (int k = 0; k < 16; k++) by[k] = w[k / 4][(k % 4) * 8 +: 8];
      n = 3'd0;
      known = 1'b1;
      four = 1'b0;
      op = vad_pkg::LANE_PASS;
      half = 1'b0;
      case (f)
         vad_pkg::FMT_FLOAT:  begin n = 3'd1; four = 1'b1; end
         vad_pkg::FMT_FLOAT2: n = 3'd2;
         vad_pkg::FMT_FLOAT3: n = 3'd3;
         vad_pkg::FMT_FLOAT4: n = 3'd4;
         vad_pkg::FMT_HALF2:  begin n = 3'd2; four = 1'b1; half = 1'b1;
                                 op = vad_pkg::LANE_HALF; end
         vad_pkg::FMT_HALF4:  begin n = 3'd4; half = 1'b1; op = vad_pkg::LANE_HALF; end
         vad_pkg::FMT_UNORM8: begin n = 3'd4; four = 1'b1; op = vad_pkg::LANE_UNORM; end
         vad_pkg::FMT_UBYTE4: begin n = 3'd4; four = 1'b1; op = vad_pkg::LANE_UBYTE; end
         vad_pkg::FMT_SNORM8: begin n = 3'd4; four = 1'b1; op = vad_pkg::LANE_SNORM; end
         default: known = 1'b0;
      endcase

      head = '0;
      for (int k = 0; k < 4; k++) begin
         ctl[k].op = vad_pkg::LANE_ZERO;
         ctl[k].trunc = 1'b0;
         ctl[k].half = half;
         ctl[k].src = half ? {16'd0, w[k / 2][(k % 2) * 16 +: 16]}
                    : ((op == vad_pkg::LANE_PASS) ? w[k] : {24'd0, by[k]});
      end

      if ({1'b0, s} < 5'(ATTR_SLOTS) && s != 4'd15 && enable_mask[s] && known) begin
         if (s == vad_pkg::SEM_INDICES && four) begin
            head = '{ok: 1'b1, attribute: 4'd6, value_count: 3'd4, is_integer: 1'b1};
            ctl[0].src = {24'd0, by[2]};
            ctl[1].src = {24'd0, by[1]};
            ctl[2].src = {24'd0, by[0]};
            ctl[3].src = {24'd0, by[3]};
            for (int k = 0; k < 4; k++) ctl[k].op = vad_pkg::LANE_INT;
         end else if (s == vad_pkg::SEM_WEIGHTS && f == vad_pkg::FMT_UNORM8) begin
            head = '{ok: 1'b1, attribute: 4'd5, value_count: 3'd4, is_integer: 1'b0};
            ctl[0].src = {24'd0, by[2]};
            ctl[1].src = {24'd0, by[1]};
            ctl[2].src = {24'd0, by[0]};
            ctl[3].src = {24'd0, by[3]};
            for (int k = 0; k < 4; k++) ctl[k].op = vad_pkg::LANE_UNORM;
         end else if ((s == vad_pkg::SEM_POSITION || s == vad_pkg::SEM_NORMAL)
                      && n >= 3'd3) begin
            head = '{ok: 1'b1, attribute: (s == vad_pkg::SEM_POSITION) ? 4'd0 : 4'd1,
                     value_count: 3'd3, is_integer: 1'b0};
            for (int k = 0; k < 3; k++) ctl[k].op = op;
         end else if ((s == vad_pkg::SEM_TANGENT || s == vad_pkg::SEM_COLOUR0
                       || s == vad_pkg::SEM_COLOUR1) && n >= 3'd4) begin
            head = '{ok: 1'b1,
                     attribute: (s == vad_pkg::SEM_TANGENT) ? 4'd2 : s - 4'd1,
                     value_count: 3'd4, is_integer: 1'b0};
            for (int k = 0; k < 4; k++) ctl[k].op = op;
         end else if (s == vad_pkg::SEM_INDICES && n >= 3'd4) begin
            // Only half4 and float4 get here; half sources go through a float first.
            head = '{ok: 1'b1, attribute: 4'd6, value_count: 3'd4, is_integer: 1'b1};
            for (int k = 0; k < 4; k++) begin
               ctl[k].op = vad_pkg::LANE_INT;
               ctl[k].trunc = 1'b1;
            end
         end else if (s == vad_pkg::SEM_WEIGHTS && n >= 3'd4) begin
            head = '{ok: 1'b1, attribute: 4'd5, value_count: 3'd4, is_integer: 1'b0};
            for (int k = 0; k < 4; k++)
               ctl[k].op = (op == vad_pkg::LANE_UBYTE) ? vad_pkg::LANE_UNORM : op;
         end else if (s >= 4'd6 && s <= 4'd13 && n >= 3'd2) begin
            head = '{ok: 1'b1, attribute: s + 4'd1, value_count: 3'd2, is_integer: 1'b0};
            for (int k = 0; k < 2; k++) ctl[k].op = op;
         end
      end
   end

endmodule
`default_nettype wire

// ----- hw/rtl/vertex_attribute_decode.sv -----
// Top level of the vertex attribute decoder: registers, lanes and the merging stage.
// One word is taken every cycle while busy is low; busy is held low, so start may be
// raised in every cycle. Each word gives one result on the rsp_ ports after the ctl_ff
// and lane value_ff registers, marked by rsp_strobe for one cycle: a front-end stage
// then four conversion lanes, one per value. The receiver cannot stall. Configuration
// writes are always ready and should only be made while no word is in flight.
`default_nettype none
module vertex_attribute_decode #(
   parameter int ATTR_SLOTS = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire vad_pkg::req_type req_data,
   output logic                  rsp_strobe,
   output vad_pkg::rsp_type      rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [0:0]       csr_index,
   input  wire logic [63:0]      csr_data
);

   logic [15:0] enable_ff, enable_in;
   logic [63:0] types_ff, types_in;
   logic        v1_ff, v1_in, v2_ff, v2_in;
   vad_pkg::head_type h0, h1_ff, h2_ff;
   vad_pkg::lane_ctl_type ctl [4];
   vad_pkg::lane_ctl_type ctl_ff [4];
   logic [31:0] lane_value [4];
   logic        accept;

   assign busy = 1'b0;
   assign csr_ready = 1'b1;
   assign accept = start && !busy;

   always_comb begin
      enable_in = enable_ff;
      types_in = types_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            vad_pkg::CSR_ENABLE_MASK: enable_in = csr_data[15:0];
            vad_pkg::CSR_TYPE_CODES:  types_in = csr_data;
            default: ;
         endcase
      end
      v1_in = accept;
      v2_in = v1_ff;
   end

   vad_front #(.ATTR_SLOTS(ATTR_SLOTS)) u_front (
      .req(req_data), .enable_mask(enable_ff), .type_codes(types_ff),
      .ctl(ctl), .head(h0)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= '0;
         types_ff <= '0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         enable_ff <= enable_in;
         types_ff <= types_in;
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      h1_ff <= h0;
      h2_ff <= h1_ff;
      for (int k = 0; k < 4; k++) ctl_ff[k] <= ctl[k];
   end

   // Half sources headed for integer truncation are widened inside the lane first.
   for (genvar g = 0; g < 4; g++) begin : g_lane
      vad_lane u_lane (.clock(clock), .ctl(ctl_ff[g]), .value_ff(lane_value[g]));
   end

   always_comb begin
      rsp_strobe = v2_ff;
      rsp_data = '0;
      if (h2_ff.ok) begin
         rsp_data.valid_res = 1'b1;
         rsp_data.attribute = h2_ff.attribute;
         rsp_data.value_count = h2_ff.value_count;
         rsp_data.is_integer = h2_ff.is_integer;
         rsp_data.value0 = lane_value[0];
         rsp_data.value1 = lane_value[1];
         rsp_data.value2 = lane_value[2];
         rsp_data.value3 = lane_value[3];
      end
   end

   a_strobe: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_strobe) else $error("result lost");
   a_noinv: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.valid_res) |-> rsp_data.value_count == 3'd0)
      else $error("invalid result with values");
   a_int: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.is_integer) |-> rsp_data.attribute == 4'd6)
      else $error("integer result on wrong attribute");

endmodule
`default_nettype wire
